FILE: design/assert_macros.svh
// Assertion macros for the design files; only dcg_ctrl uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define DCG_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define DCG_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define DCG_ASSERT(lbl, clk, rstn, prop)
`define DCG_ASSERT_NR(lbl, clk, prop)
`endif

`endif

FILE: design/dcg_pkg.sv
package dcg_pkg;

  localparam int unsigned DIM_W      = 9;
  localparam int unsigned INV_W      = 16;
  localparam int unsigned VOXEL_IN_W = 16;
  localparam int unsigned NORM_W     = 48;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CRD_W      = 13;
  localparam int unsigned SQ_IN_W    = 27;
  localparam int unsigned SQ_W       = 54;
  localparam int unsigned ACC_W      = 56;
  localparam int unsigned A_LIMIT_SH = 25;
  localparam int unsigned B_LIMIT_SH = 27;

  localparam int unsigned NB_COUNT   = 19;
  localparam int unsigned NB_W       = 5;
  localparam int unsigned FACE_COUNT = 6;
  localparam int unsigned FACE_W     = 3;
  localparam int unsigned PHASE_W    = 3;

  localparam logic [NORM_W-1:0] NORM_MAX = '1;
  localparam logic [DIM_W-1:0]  DIM_RESET = 9'd256;
  localparam logic [INV_W-1:0]  INV_RESET = 16'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLUMNS = 3'd0,
    REG_ROWS    = 3'd1,
    REG_SLICES  = 3'd2,
    REG_INV_X   = 3'd3,
    REG_INV_Y   = 3'd4,
    REG_INV_Z   = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OFF_ZERO  = 2'd0,
    OFF_MINUS = 2'd1,
    OFF_PLUS  = 2'd2
  } off_e;

  typedef struct packed {
    off_e dc;
    off_e dr;
    off_e ds;
  } nb_off_t;

  // neighbourhood slots
  localparam logic [NB_W-1:0] NB_U   = 5'd0;
  localparam logic [NB_W-1:0] NB_N   = 5'd1;
  localparam logic [NB_W-1:0] NB_S   = 5'd2;
  localparam logic [NB_W-1:0] NB_E   = 5'd3;
  localparam logic [NB_W-1:0] NB_W_  = 5'd4;
  localparam logic [NB_W-1:0] NB_NE  = 5'd5;
  localparam logic [NB_W-1:0] NB_NW  = 5'd6;
  localparam logic [NB_W-1:0] NB_SE  = 5'd7;
  localparam logic [NB_W-1:0] NB_SW  = 5'd8;
  localparam logic [NB_W-1:0] NB_TU  = 5'd9;
  localparam logic [NB_W-1:0] NB_TN  = 5'd10;
  localparam logic [NB_W-1:0] NB_TS  = 5'd11;
  localparam logic [NB_W-1:0] NB_TE  = 5'd12;
  localparam logic [NB_W-1:0] NB_TW  = 5'd13;
  localparam logic [NB_W-1:0] NB_BU  = 5'd14;
  localparam logic [NB_W-1:0] NB_BN  = 5'd15;
  localparam logic [NB_W-1:0] NB_BS  = 5'd16;
  localparam logic [NB_W-1:0] NB_BE  = 5'd17;
  localparam logic [NB_W-1:0] NB_BW  = 5'd18;
  localparam logic [NB_W-1:0] NB_LAST = 5'd18;

  localparam logic [FACE_W-1:0] FACE_EAST   = 3'd0;
  localparam logic [FACE_W-1:0] FACE_WEST   = 3'd1;
  localparam logic [FACE_W-1:0] FACE_NORTH  = 3'd2;
  localparam logic [FACE_W-1:0] FACE_SOUTH  = 3'd3;
  localparam logic [FACE_W-1:0] FACE_TOP    = 3'd4;
  localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd5;

  localparam logic [PHASE_W-1:0] PH_A   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_B   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_C   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_SQA = 3'd3;
  localparam logic [PHASE_W-1:0] PH_SQB = 3'd4;
  localparam logic [PHASE_W-1:0] PH_SQC = 3'd5;
  localparam logic [PHASE_W-1:0] PH_ACC = 3'd6;
  localparam logic [PHASE_W-1:0] PH_OUT = 3'd7;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_WRITE = 6'b000010,
    ST_CHECK = 6'b000100,
    ST_FETCH = 6'b001000,
    ST_CALC  = 6'b010000,
    ST_OUT   = 6'b100000
  } state_e;

  typedef struct packed {
    logic              take;
    logic              write;
    logic              rd_en;
    logic [NB_W-1:0]   rd_idx;
    logic              cap_en;
    logic [NB_W-1:0]   cap_idx;
    logic              calc_en;
    logic [FACE_W-1:0] face;
    logic [PHASE_W-1:0] phase;
    logic              emit;
  } dcg_cmd_t;

  typedef struct packed {
    logic ready;
    logic last;
  } dcg_status_t;

  function automatic nb_off_t nb_offset(input logic [NB_W-1:0] idx);
    nb_off_t o;
    o = '{dc: OFF_ZERO, dr: OFF_ZERO, ds: OFF_ZERO};
    case (idx)
      NB_N:  o.dr = OFF_MINUS;
      NB_S:  o.dr = OFF_PLUS;
      NB_E:  o.dc = OFF_PLUS;
      NB_W_: o.dc = OFF_MINUS;
      NB_NE: begin o.dc = OFF_PLUS;  o.dr = OFF_MINUS; end
      NB_NW: begin o.dc = OFF_MINUS; o.dr = OFF_MINUS; end
      NB_SE: begin o.dc = OFF_PLUS;  o.dr = OFF_PLUS;  end
      NB_SW: begin o.dc = OFF_MINUS; o.dr = OFF_PLUS;  end
      NB_TU: o.ds = OFF_MINUS;
      NB_TN: begin o.ds = OFF_MINUS; o.dr = OFF_MINUS; end
      NB_TS: begin o.ds = OFF_MINUS; o.dr = OFF_PLUS;  end
      NB_TE: begin o.ds = OFF_MINUS; o.dc = OFF_PLUS;  end
      NB_TW: begin o.ds = OFF_MINUS; o.dc = OFF_MINUS; end
      NB_BU: o.ds = OFF_PLUS;
      NB_BN: begin o.ds = OFF_PLUS; o.dr = OFF_MINUS; end
      NB_BS: begin o.ds = OFF_PLUS; o.dr = OFF_PLUS;  end
      NB_BE: begin o.ds = OFF_PLUS; o.dc = OFF_PLUS;  end
      NB_BW: begin o.ds = OFF_PLUS; o.dc = OFF_MINUS; end
      default: o = '{dc: OFF_ZERO, dr: OFF_ZERO, ds: OFF_ZERO};
    endcase
    return o;
  endfunction

  // highest coordinate in use: zero acts as one, clip at the maximum
  function automatic logic [CRD_W-1:0] dim_m1(input logic [DIM_W-1:0] v,
                                              input int unsigned maxv);
    if (v == '0) return '0;
    if (32'(v) > maxv) return CRD_W'(maxv - 1);
    return CRD_W'(v) - CRD_W'(1);
  endfunction

  // neighbour coordinate held to the volume
  function automatic logic [CRD_W-1:0] step_coord(input logic [CRD_W-1:0] q,
                                                  input off_e off,
                                                  input logic [CRD_W-1:0] nm1);
    case (off)
      OFF_MINUS: return (q == '0) ? '0 : q - CRD_W'(1);
      OFF_PLUS:  return (q < nm1) ? q + CRD_W'(1) : nm1;
      default:   return q;
    endcase
  endfunction

endpackage

FILE: design/dcg_ram.sv
module dcg_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: design/dcg_ctrl.sv
`include "assert_macros.svh"

module dcg_ctrl import dcg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  input  dcg_status_t status_i,
  output dcg_cmd_t    cmd_o
);

  state_e              state_q, state_d;
  logic [NB_W-1:0]     step_q, step_d;
  logic [FACE_W-1:0]   face_q, face_d;
  logic [PHASE_W-1:0]  phase_q, phase_d;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    face_d  = face_q;
    phase_d = phase_q;
    cmd_o   = '0;
    cmd_o.face  = face_q;
    cmd_o.phase = phase_q;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd_o.write = 1'b1;
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        step_d = '0;
        state_d = status_i.ready ? ST_FETCH : ST_IDLE;
      end
      ST_FETCH: begin
        cmd_o.rd_en   = (step_q <= NB_LAST);
        cmd_o.rd_idx  = step_q;
        cmd_o.cap_en  = (step_q != '0);
        cmd_o.cap_idx = step_q - NB_W'(1);
        if (step_q == NB_LAST + NB_W'(1)) begin
          face_d  = '0;
          phase_d = '0;
          state_d = ST_CALC;
        end else begin
          step_d = step_q + NB_W'(1);
        end
      end
      ST_CALC: begin
        cmd_o.calc_en = 1'b1;
        phase_d = phase_q + PHASE_W'(1);
        if (phase_q == PH_OUT) begin
          face_d = face_q + FACE_W'(1);
          if (face_q == FACE_BOTTOM) begin
            state_d = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          cmd_o.emit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      face_q  <= '0;
      phase_q <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      face_q  <= face_d;
      phase_q <= phase_d;
    end
  end

  `DCG_ASSERT(a_no_take_while_result, clk_i, rst_ni, out_valid_o |-> in_stall_o)
  `DCG_ASSERT(a_result_after_calc, clk_i, rst_ni, $rose(out_valid_o) |-> $past(state_q == ST_CALC))
  `DCG_ASSERT(a_capture_after_read, clk_i, rst_ni, cmd_o.cap_en |-> $past(cmd_o.rd_en))

endmodule

FILE: design/dcg_datapath.sv
module dcg_datapath import dcg_pkg::*; #(
  parameter int unsigned MAX_COLUMNS = 256,
  parameter int unsigned MAX_ROWS    = 256,
  parameter int unsigned MAX_SLICES  = 256,
  parameter int unsigned VOXEL_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  op_i,
  input  logic [VOXEL_IN_W-1:0] voxel_value_i,
  input  dcg_cmd_t              cmd_i,
  output dcg_status_t           status_o,
  output logic [NORM_W-1:0]     east_norm_o,
  output logic [NORM_W-1:0]     west_norm_o,
  output logic [NORM_W-1:0]     north_norm_o,
  output logic [NORM_W-1:0]     south_norm_o,
  output logic [NORM_W-1:0]     top_norm_o,
  output logic [NORM_W-1:0]     bottom_norm_o
);

  localparam int unsigned CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned SW = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
  localparam int unsigned SLICE_SIZE = MAX_COLUMNS * MAX_ROWS;
  localparam int unsigned DEPTH = 4 * SLICE_SIZE;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned MAG_W = VOXEL_BITS + 1;
  localparam int unsigned PROD_W = MAG_W + INV_W;
  localparam int unsigned MUL_W = (MAG_W > SQ_IN_W) ? MAG_W : SQ_IN_W;

  logic [DIM_W-1:0] cols_q, rows_q, slices_q;
  logic [INV_W-1:0] inv_x_q, inv_y_q, inv_z_q;
  logic             op_q;
  logic [VOXEL_IN_W-1:0] vox_q;
  logic [CW-1:0]    pc_q, qc_q;
  logic [RW-1:0]    pr_q, qr_q;
  logic [SW-1:0]    ps_q, qs_q;
  logic             in_full_q;

  logic [CW-1:0] ncm1;
  logic [RW-1:0] nrm1;
  logic [SW-1:0] nsm1;

  assign ncm1 = CW'(dim_m1(cols_q, MAX_COLUMNS));
  assign nrm1 = RW'(dim_m1(rows_q, MAX_ROWS));
  assign nsm1 = SW'(dim_m1(slices_q, MAX_SLICES));

  logic last;
  assign last = (qc_q == ncm1) && (qr_q == nrm1) && (qs_q == nsm1);

  // readiness: the volume is full, or the input has passed the far corner neighbour
  logic [CRD_W-1:0] nx, ny, nz;
  logic             lex_gt;
  assign nx = step_coord(CRD_W'(qc_q), OFF_PLUS, CRD_W'(ncm1));
  assign ny = step_coord(CRD_W'(qr_q), OFF_PLUS, CRD_W'(nrm1));
  assign nz = step_coord(CRD_W'(qs_q), OFF_PLUS, CRD_W'(nsm1));
  assign lex_gt = (CRD_W'(ps_q) > nz) ||
                  ((CRD_W'(ps_q) == nz) && ((CRD_W'(pr_q) > ny) ||
                   ((CRD_W'(pr_q) == ny) && (CRD_W'(pc_q) > nx))));
  assign status_o.ready = in_full_q || lex_gt;
  assign status_o.last  = last;

  logic do_write;
  assign do_write = cmd_i.write && !op_q && !in_full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q    <= DIM_RESET;
      rows_q    <= DIM_RESET;
      slices_q  <= DIM_RESET;
      inv_x_q   <= INV_RESET;
      inv_y_q   <= INV_RESET;
      inv_z_q   <= INV_RESET;
      pc_q      <= '0;
      pr_q      <= '0;
      ps_q      <= '0;
      qc_q      <= '0;
      qr_q      <= '0;
      qs_q      <= '0;
      in_full_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_COLUMNS, REG_ROWS, REG_SLICES: begin
          if (cfg_reg_e'(cfg_idx_i) == REG_COLUMNS) cols_q <= cfg_data_i[DIM_W-1:0];
          if (cfg_reg_e'(cfg_idx_i) == REG_ROWS) rows_q <= cfg_data_i[DIM_W-1:0];
          if (cfg_reg_e'(cfg_idx_i) == REG_SLICES) slices_q <= cfg_data_i[DIM_W-1:0];
          pc_q      <= '0;
          pr_q      <= '0;
          ps_q      <= '0;
          qc_q      <= '0;
          qr_q      <= '0;
          qs_q      <= '0;
          in_full_q <= 1'b0;
        end
        REG_INV_X: inv_x_q <= cfg_data_i;
        REG_INV_Y: inv_y_q <= cfg_data_i;
        REG_INV_Z: inv_z_q <= cfg_data_i;
        default: ;
      endcase
    end else if (cmd_i.emit) begin
      if (last) begin
        pc_q      <= '0;
        pr_q      <= '0;
        ps_q      <= '0;
        qc_q      <= '0;
        qr_q      <= '0;
        qs_q      <= '0;
        in_full_q <= 1'b0;
      end else if (qc_q != ncm1) begin
        qc_q <= qc_q + CW'(1);
      end else begin
        qc_q <= '0;
        if (qr_q != nrm1) begin
          qr_q <= qr_q + RW'(1);
        end else begin
          qr_q <= '0;
          qs_q <= qs_q + SW'(1);
        end
      end
    end else if (do_write) begin
      if (pc_q != ncm1) begin
        pc_q <= pc_q + CW'(1);
      end else begin
        pc_q <= '0;
        if (pr_q != nrm1) begin
          pr_q <= pr_q + RW'(1);
        end else begin
          pr_q <= '0;
          if (ps_q != nsm1) begin
            ps_q <= ps_q + SW'(1);
          end else begin
            in_full_q <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      op_q  <= op_i;
      vox_q <= voxel_value_i;
    end
  end

  // ring addressing
  nb_off_t       off;
  logic [CW-1:0] rc;
  logic [RW-1:0] rr;
  logic [SW-1:0] rs;
  logic [AW-1:0] raddr, waddr;
  logic [VOXEL_BITS-1:0] rdata;

  assign off = nb_offset(cmd_i.rd_idx);
  assign rc = CW'(step_coord(CRD_W'(qc_q), off.dc, CRD_W'(ncm1)));
  assign rr = RW'(step_coord(CRD_W'(qr_q), off.dr, CRD_W'(nrm1)));
  assign rs = SW'(step_coord(CRD_W'(qs_q), off.ds, CRD_W'(nsm1)));
  assign raddr = AW'(32'(2'(rs)) * SLICE_SIZE + 32'(rr) * MAX_COLUMNS + 32'(rc));
  assign waddr = AW'(32'(2'(ps_q)) * SLICE_SIZE + 32'(pr_q) * MAX_COLUMNS + 32'(pc_q));

  dcg_ram #(
    .WIDTH (VOXEL_BITS),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (do_write),
    .waddr_i (waddr),
    .wdata_i (VOXEL_BITS'(vox_q)),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  logic [VOXEL_BITS-1:0] nb_q [NB_COUNT];

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_en) begin
      nb_q[cmd_i.cap_idx] <= rdata;
    end
  end

  function automatic logic [MAG_W-1:0] fmag(input logic [VOXEL_BITS-1:0] x,
                                            input logic [VOXEL_BITS-1:0] y);
    return (x >= y) ? MAG_W'(x) - MAG_W'(y) : MAG_W'(y) - MAG_W'(x);
  endfunction

  function automatic logic [MAG_W-1:0] cmag(input logic [VOXEL_BITS-1:0] a,
                                            input logic [VOXEL_BITS-1:0] b,
                                            input logic [VOXEL_BITS-1:0] c,
                                            input logic [VOXEL_BITS-1:0] d);
    logic [MAG_W-1:0] s1, s2;
    s1 = MAG_W'(a) + MAG_W'(b);
    s2 = MAG_W'(c) + MAG_W'(d);
    return (s1 >= s2) ? s1 - s2 : s2 - s1;
  endfunction

  logic [MAG_W-1:0] mag_f, mag_1, mag_2;
  logic [INV_W-1:0] inv_f, inv_1, inv_2;

  always_comb begin
    case (cmd_i.face)
      FACE_EAST: begin
        mag_f = fmag(nb_q[NB_E], nb_q[NB_U]);
        mag_1 = cmag(nb_q[NB_N], nb_q[NB_NE], nb_q[NB_S], nb_q[NB_SE]);
        mag_2 = cmag(nb_q[NB_TU], nb_q[NB_TE], nb_q[NB_BU], nb_q[NB_BE]);
        inv_f = inv_x_q; inv_1 = inv_y_q; inv_2 = inv_z_q;
      end
      FACE_WEST: begin
        mag_f = fmag(nb_q[NB_W_], nb_q[NB_U]);
        mag_1 = cmag(nb_q[NB_NW], nb_q[NB_N], nb_q[NB_SW], nb_q[NB_S]);
        mag_2 = cmag(nb_q[NB_TW], nb_q[NB_TU], nb_q[NB_BW], nb_q[NB_BU]);
        inv_f = inv_x_q; inv_1 = inv_y_q; inv_2 = inv_z_q;
      end
      FACE_NORTH: begin
        mag_f = fmag(nb_q[NB_N], nb_q[NB_U]);
        mag_1 = cmag(nb_q[NB_NE], nb_q[NB_E], nb_q[NB_NW], nb_q[NB_W_]);
        mag_2 = cmag(nb_q[NB_TN], nb_q[NB_TU], nb_q[NB_BN], nb_q[NB_BU]);
        inv_f = inv_y_q; inv_1 = inv_x_q; inv_2 = inv_z_q;
      end
      FACE_SOUTH: begin
        mag_f = fmag(nb_q[NB_S], nb_q[NB_U]);
        mag_1 = cmag(nb_q[NB_E], nb_q[NB_SE], nb_q[NB_W_], nb_q[NB_SW]);
        mag_2 = cmag(nb_q[NB_TS], nb_q[NB_TU], nb_q[NB_BS], nb_q[NB_BU]);
        inv_f = inv_y_q; inv_1 = inv_x_q; inv_2 = inv_z_q;
      end
      FACE_TOP: begin
        mag_f = fmag(nb_q[NB_TU], nb_q[NB_U]);
        mag_1 = cmag(nb_q[NB_TE], nb_q[NB_E], nb_q[NB_TW], nb_q[NB_W_]);
        mag_2 = cmag(nb_q[NB_TN], nb_q[NB_N], nb_q[NB_TS], nb_q[NB_S]);
        inv_f = inv_z_q; inv_1 = inv_x_q; inv_2 = inv_y_q;
      end
      FACE_BOTTOM: begin
        mag_f = fmag(nb_q[NB_BU], nb_q[NB_U]);
        mag_1 = cmag(nb_q[NB_BW], nb_q[NB_W_], nb_q[NB_BE], nb_q[NB_E]);
        mag_2 = cmag(nb_q[NB_BN], nb_q[NB_N], nb_q[NB_BS], nb_q[NB_S]);
        inv_f = inv_z_q; inv_1 = inv_x_q; inv_2 = inv_y_q;
      end
      default: begin
        mag_f = '0; mag_1 = '0; mag_2 = '0;
        inv_f = '0; inv_1 = '0; inv_2 = '0;
      end
    endcase
  end

  logic [PROD_W-1:0]  a_q, b_q, c_q;
  logic [SQ_W-1:0]    sq_q;
  logic [ACC_W-1:0]   acc_q;
  logic [MUL_W-1:0]   op_a, op_b;
  logic [2*MUL_W-1:0] product;
  logic [NORM_W-1:0]  norm_q [FACE_COUNT];
  logic               sat;
  logic [ACC_W-1:0]   scaled;

  always_comb begin
    case (cmd_i.phase)
      PH_A:   begin op_a = MUL_W'(mag_f); op_b = MUL_W'(inv_f); end
      PH_B:   begin op_a = MUL_W'(mag_1); op_b = MUL_W'(inv_1); end
      PH_C:   begin op_a = MUL_W'(mag_2); op_b = MUL_W'(inv_2); end
      PH_SQA: begin op_a = MUL_W'(a_q);   op_b = MUL_W'(a_q);   end
      PH_SQB: begin op_a = MUL_W'(b_q);   op_b = MUL_W'(b_q);   end
      PH_SQC: begin op_a = MUL_W'(c_q);   op_b = MUL_W'(c_q);   end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  assign product = op_a * op_b;
  assign sat = ((a_q >> A_LIMIT_SH) != '0) || ((b_q >> B_LIMIT_SH) != '0) ||
               ((c_q >> B_LIMIT_SH) != '0);
  assign scaled = acc_q >> 4;

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_en) begin
      case (cmd_i.phase)
        PH_A:   a_q <= PROD_W'(product);
        PH_B:   b_q <= PROD_W'(product);
        PH_C:   c_q <= PROD_W'(product);
        PH_SQA: sq_q <= SQ_W'(product);
        PH_SQB: begin
          acc_q <= ACC_W'(sq_q) << 4;
          sq_q  <= SQ_W'(product);
        end
        PH_SQC: begin
          acc_q <= acc_q + ACC_W'(sq_q);
          sq_q  <= SQ_W'(product);
        end
        PH_ACC: acc_q <= acc_q + ACC_W'(sq_q);
        PH_OUT: begin
          if (sat || (scaled > ACC_W'(NORM_MAX))) begin
            norm_q[cmd_i.face] <= NORM_MAX;
          end else begin
            norm_q[cmd_i.face] <= scaled[NORM_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  assign east_norm_o   = norm_q[FACE_EAST];
  assign west_norm_o   = norm_q[FACE_WEST];
  assign north_norm_o  = norm_q[FACE_NORTH];
  assign south_norm_o  = norm_q[FACE_SOUTH];
  assign top_norm_o    = norm_q[FACE_TOP];
  assign bottom_norm_o = norm_q[FACE_BOTTOM];

endmodule

FILE: design/diamond_cell_gradient_norm_3d.sv
// Channel   Direction  Handshake                Beat
// in        sink       in_valid_i / in_stall_o   op_i, voxel_value_i
// out       source     out_valid_o / out_stall_i six face norms, last_voxel_o
// cfg       sink       cfg_we_i                  cfg_idx_i, cfg_data_i
//
// A beat with no result passes the idle, write and check states; one with a
// result also passes fetch (19 neighbour reads through the single read port of
// the slice ring), calc (8 steps per face on the one shared multiplier) and out.
// The slice ring has no reset; reset clears only positions, config and FSM state.
// A stalled result holds the block; the next input beat is taken after it.
module diamond_cell_gradient_norm_3d import dcg_pkg::*; #(
  parameter int unsigned MAX_COLUMNS = 256,
  parameter int unsigned MAX_ROWS    = 256,
  parameter int unsigned MAX_SLICES  = 256,
  parameter int unsigned VOXEL_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  op_i,
  input  logic [VOXEL_IN_W-1:0] voxel_value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [NORM_W-1:0]     east_norm_o,
  output logic [NORM_W-1:0]     west_norm_o,
  output logic [NORM_W-1:0]     north_norm_o,
  output logic [NORM_W-1:0]     south_norm_o,
  output logic [NORM_W-1:0]     top_norm_o,
  output logic [NORM_W-1:0]     bottom_norm_o,
  output logic                  last_voxel_o
);

  dcg_cmd_t    cmd;
  dcg_status_t status;

  dcg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  dcg_datapath #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .MAX_SLICES  (MAX_SLICES),
    .VOXEL_BITS  (VOXEL_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .op_i          (op_i),
    .voxel_value_i (voxel_value_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .east_norm_o   (east_norm_o),
    .west_norm_o   (west_norm_o),
    .north_norm_o  (north_norm_o),
    .south_norm_o  (south_norm_o),
    .top_norm_o    (top_norm_o),
    .bottom_norm_o (bottom_norm_o)
  );

  assign last_voxel_o = status.last;

endmodule
